// File: hdl/stack_word_multiply_divide_unit_top_macros.svh
// assertion macros for the multiply and divide unit
`ifndef STACK_WORD_MULTIPLY_DIVIDE_UNIT_TOP_MACROS_SVH
`define STACK_WORD_MULTIPLY_DIVIDE_UNIT_TOP_MACROS_SVH

// same-cycle implication
`define SWMD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swmd assertion failed");

// next-cycle implication
`define SWMD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swmd assertion failed");

`endif

// File: hdl/swmd_pkg.sv
package swmd_pkg;

    localparam int CELL_BITS = 32;
    localparam int DBL_BITS = 2 * CELL_BITS;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef enum logic [3:0] {
        CMD_STAR         = 4'd0,
        CMD_STARSLASH    = 4'd1,
        CMD_STARSLASHMOD = 4'd2,
        CMD_SLASH        = 4'd3,
        CMD_SLASHMOD     = 4'd4,
        CMD_MOD          = 4'd5,
        CMD_FMSLASHMOD   = 4'd6,
        CMD_SMSLASHREM   = 4'd7,
        CMD_MSTAR        = 4'd8,
        CMD_UMSTAR       = 4'd9,
        CMD_UMSLASHMOD   = 4'd10
    } cmd_t;

    typedef struct packed {
        cmd_t                   cmd;
        logic [CELL_BITS-1:0]   a;
        logic [CELL_BITS-1:0]   b;
        logic [CELL_BITS-1:0]   c;
        logic [CELL_BITS-1:0]   ma;
        logic [CELL_BITS-1:0]   mb;
        logic [CELL_BITS-1:0]   v;
        logic [CELL_BITS-1:0]   sh;
        logic                   dneg;
        logic                   qneg;
        logic                   rneg;
        logic                   fm;
        logic                   st;
    } item_t;

    typedef struct packed {
        cmd_t                   cmd;
        logic [CELL_BITS-1:0]   c;
        logic [CELL_BITS-1:0]   mlo;
        logic [CELL_BITS-1:0]   mhi;
        logic                   qneg;
        logic                   rneg;
        logic                   fm;
        logic                   st;
    } meta_t;

    typedef struct packed {
        logic [CELL_BITS-1:0]   rem;
        logic [DBL_BITS-1:0]    dq;
        logic [CELL_BITS-1:0]   v;
        meta_t                  m;
    } dstage_t;

    typedef struct packed {
        logic [CELL_BITS-1:0]   lo;
        logic [CELL_BITS-1:0]   hi;
        logic                   st;
    } res_t;

endpackage

// File: hdl/swmd_queue.sv
module swmd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  swmd_pkg::item_t wdata,
    output logic            full,
    input  logic            rd,
    output swmd_pkg::item_t rdata,
    output logic            empty
);
    import swmd_pkg::*;

    item_t              mem [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg;
    logic [QCNT_W-1:0]  cnt_next;
    logic               do_wr;
    logic               do_rd;

    assign full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: hdl/swmd_front.sv
module swmd_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [3:0]                      cmd,
    input  logic [swmd_pkg::CELL_BITS-1:0]  operand_a,
    input  logic [swmd_pkg::CELL_BITS-1:0]  operand_b,
    input  logic [swmd_pkg::CELL_BITS-1:0]  operand_c,
    output logic                            q_wr,
    output swmd_pkg::item_t                 q_wdata,
    input  logic                            q_full
);
    import swmd_pkg::*;

    item_t                  it;
    item_t                  fr_item_reg;
    logic                   fr_valid_reg;
    logic                   fr_valid_next;
    logic                   take;
    logic                   na;
    logic                   nb;
    logic                   nc;
    logic                   sp;
    logic [CELL_BITS-1:0]   abs_a;
    logic [CELL_BITS-1:0]   abs_b;
    logic [CELL_BITS-1:0]   abs_c;

    assign full    = fr_valid_reg && q_full;
    assign take    = push && !full;
    assign q_wr    = fr_valid_reg && !q_full;
    assign q_wdata = fr_item_reg;

    assign na    = operand_a[CELL_BITS-1];
    assign nb    = operand_b[CELL_BITS-1];
    assign nc    = operand_c[CELL_BITS-1];
    assign sp    = na ^ nb;
    assign abs_a = na ? -operand_a : operand_a;
    assign abs_b = nb ? -operand_b : operand_b;
    assign abs_c = nc ? -operand_c : operand_c;

    // classify the item and prepare operands
    always_comb
    begin
        it      = '0;
        it.cmd  = cmd_t'(cmd);
        it.a    = operand_a;
        it.b    = operand_b;
        it.c    = operand_c;
        it.ma   = operand_a;
        it.mb   = operand_b;
        it.v    = operand_c;
        it.sh   = (na ? operand_b : '0) + (nb ? operand_a : '0);
        case (cmd_t'(cmd))
            CMD_STARSLASH, CMD_STARSLASHMOD:
            begin
                it.ma   = abs_a;
                it.mb   = abs_b;
                it.v    = abs_c;
                it.st   = (operand_c == '0);
                it.rneg = sp;
                it.qneg = sp ^ nc;
            end
            CMD_SLASH, CMD_SLASHMOD, CMD_MOD:
            begin
                it.ma   = abs_a;
                it.v    = abs_b;
                it.st   = (operand_b == '0);
                it.rneg = na;
                it.qneg = na ^ nb;
            end
            CMD_FMSLASHMOD, CMD_SMSLASHREM:
            begin
                it.v    = abs_c;
                it.st   = (operand_c == '0);
                it.dneg = nb;
                it.rneg = nb;
                it.qneg = nb ^ nc;
                it.fm   = (cmd_t'(cmd) == CMD_FMSLASHMOD);
            end
            CMD_UMSLASHMOD:
            begin
                it.st = (operand_c == '0);
            end
            default:
            begin
            end
        endcase
    end

    assign fr_valid_next = take || full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            fr_item_reg <= it;
        end
    end

endmodule

// File: hdl/swmd_back.sv
module swmd_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    input  swmd_pkg::item_t                 q_rdata,
    output logic                            q_rd,
    output logic                            empty,
    input  logic                            pop,
    output logic [swmd_pkg::CELL_BITS-1:0]  result_low,
    output logic [swmd_pkg::CELL_BITS-1:0]  result_high,
    output logic                            status
);
    import swmd_pkg::*;

    localparam int NSTEP = DBL_BITS;

    function automatic dstage_t div_step(input dstage_t x);
        dstage_t            y;
        logic [CELL_BITS:0] rs;
        logic               ge;
        y  = x;
        rs = {x.rem, x.dq[DBL_BITS-1]};
        ge = (rs >= {1'b0, x.v});
        y.rem = ge ? (rs[CELL_BITS-1:0] - x.v) : rs[CELL_BITS-1:0];
        y.dq  = {x.dq[DBL_BITS-2:0], ge};
        return y;
    endfunction

    logic                   en;
    logic                   s0_valid_reg;
    item_t                  s0_reg;
    logic                   mp_valid_reg;
    item_t                  mp_reg;
    logic [DBL_BITS-1:0]    mp_p_reg;
    logic [DBL_BITS-1:0]    prod;
    logic [DBL_BITS-1:0]    ba;
    dstage_t                d0;
    logic                   dv_reg [0:NSTEP];
    dstage_t                ds_reg [0:NSTEP];
    dstage_t                ds_next [1:NSTEP];
    logic                   f1_valid_reg;
    logic [CELL_BITS-1:0]   f1_q_reg;
    logic [CELL_BITS-1:0]   f1_r_reg;
    meta_t                  f1_m_reg;
    logic [CELL_BITS-1:0]   qf;
    logic [CELL_BITS-1:0]   rf;
    logic                   adj;
    res_t                   res;
    res_t                   oq_mem [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0]      oq_wr_ptr_reg;
    logic [QPTR_W-1:0]      oq_rd_ptr_reg;
    logic [QCNT_W-1:0]      oq_cnt_reg;
    logic [QCNT_W-1:0]      oq_cnt_next;
    logic                   oq_full;
    logic                   oq_wr;
    logic                   oq_rd;

    assign oq_full = (oq_cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (oq_cnt_reg == '0);
    assign en      = !oq_full;
    assign q_rd    = en && !q_empty;
    assign oq_wr   = en && f1_valid_reg;
    assign oq_rd   = pop && !empty;

    assign result_low  = oq_mem[oq_rd_ptr_reg].lo;
    assign result_high = oq_mem[oq_rd_ptr_reg].hi;
    assign status      = oq_mem[oq_rd_ptr_reg].st;

    assign prod = s0_reg.ma * s0_reg.mb;
    assign ba   = {mp_reg.b, mp_reg.a};

    // dividend and multiply results
    always_comb
    begin
        d0        = '0;
        d0.v      = mp_reg.v;
        d0.dq     = ba;
        d0.m.cmd  = mp_reg.cmd;
        d0.m.c    = mp_reg.c;
        d0.m.qneg = mp_reg.qneg;
        d0.m.rneg = mp_reg.rneg;
        d0.m.fm   = mp_reg.fm;
        d0.m.st   = mp_reg.st;
        d0.m.mlo  = mp_p_reg[CELL_BITS-1:0];
        d0.m.mhi  = mp_p_reg[DBL_BITS-1:CELL_BITS];
        case (mp_reg.cmd)
            CMD_STAR:
            begin
                d0.m.mhi = '0;
            end
            CMD_MSTAR:
            begin
                d0.m.mhi = mp_p_reg[DBL_BITS-1:CELL_BITS] - mp_reg.sh;
            end
            CMD_STARSLASH, CMD_STARSLASHMOD:
            begin
                d0.dq = mp_p_reg;
            end
            CMD_SLASH, CMD_SLASHMOD, CMD_MOD:
            begin
                d0.dq = {{CELL_BITS{1'b0}}, mp_reg.ma};
            end
            CMD_FMSLASHMOD, CMD_SMSLASHREM:
            begin
                d0.dq = mp_reg.dneg ? -ba : ba;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        for (int i = 1; i <= NSTEP; i++)
        begin
            ds_next[i] = div_step(ds_reg[i-1]);
        end
    end

    // floored adjustment and result select
    always_comb
    begin
        adj = f1_m_reg.fm && (f1_r_reg != '0)
            && (f1_r_reg[CELL_BITS-1] != f1_m_reg.c[CELL_BITS-1]);
        qf  = adj ? f1_q_reg - 1'b1 : f1_q_reg;
        rf  = adj ? f1_r_reg + f1_m_reg.c : f1_r_reg;
        res = '0;
        case (f1_m_reg.cmd)
            CMD_STAR, CMD_MSTAR, CMD_UMSTAR:
            begin
                res.lo = f1_m_reg.mlo;
                res.hi = f1_m_reg.mhi;
            end
            CMD_STARSLASH, CMD_SLASH:
            begin
                res.lo = qf;
            end
            CMD_MOD:
            begin
                res.lo = rf;
            end
            CMD_STARSLASHMOD, CMD_SLASHMOD, CMD_FMSLASHMOD, CMD_SMSLASHREM,
            CMD_UMSLASHMOD:
            begin
                res.lo = rf;
                res.hi = qf;
            end
            default:
            begin
            end
        endcase
        if (f1_m_reg.st)
        begin
            res = '0;
            res.st = 1'b1;
        end
    end

    always_comb
    begin
        oq_cnt_next = oq_cnt_reg;
        if (oq_wr && !oq_rd)
        begin
            oq_cnt_next = oq_cnt_reg + 1'b1;
        end
        else if (oq_rd && !oq_wr)
        begin
            oq_cnt_next = oq_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            mp_valid_reg  <= 1'b0;
            f1_valid_reg  <= 1'b0;
            for (int i = 0; i <= NSTEP; i++)
            begin
                dv_reg[i] <= 1'b0;
            end
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_cnt_reg    <= '0;
        end
        else
        begin
            if (en)
            begin
                s0_valid_reg <= q_rd;
                mp_valid_reg <= s0_valid_reg;
                dv_reg[0]    <= mp_valid_reg;
                for (int i = 1; i <= NSTEP; i++)
                begin
                    dv_reg[i] <= dv_reg[i-1];
                end
                f1_valid_reg <= dv_reg[NSTEP];
            end
            if (oq_wr)
            begin
                oq_wr_ptr_reg <= oq_wr_ptr_reg + 1'b1;
            end
            if (oq_rd)
            begin
                oq_rd_ptr_reg <= oq_rd_ptr_reg + 1'b1;
            end
            oq_cnt_reg <= oq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg    <= q_rdata;
            mp_reg    <= s0_reg;
            mp_p_reg  <= prod;
            ds_reg[0] <= d0;
            for (int i = 1; i <= NSTEP; i++)
            begin
                ds_reg[i] <= ds_next[i];
            end
            f1_q_reg <= ds_reg[NSTEP].m.qneg ? -ds_reg[NSTEP].dq[CELL_BITS-1:0]
                                              : ds_reg[NSTEP].dq[CELL_BITS-1:0];
            f1_r_reg <= ds_reg[NSTEP].m.rneg ? -ds_reg[NSTEP].rem : ds_reg[NSTEP].rem;
            f1_m_reg <= ds_reg[NSTEP].m;
        end
        if (oq_wr)
        begin
            oq_mem[oq_wr_ptr_reg] <= res;
        end
    end

endmodule

// File: hdl/stack_word_multiply_divide_unit_top.sv
// Multiply and divide unit for the Forth core words on 32-bit cells. Push one
// item per cycle while full is low; results come back in order, one per item,
// through input register, four-entry queue, multiply stage, dividend set-up,
// a 64-stage restoring divider that forms one quotient bit per stage, sign
// and floor correction, four-entry result queue. The divider pipeline and the
// single 32x32 multiplier stage set the latency; throughput is one item per
// cycle while pop keeps up. A zero divisor returns status 1 with zero cells.
module stack_word_multiply_divide_unit_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [3:0]                      cmd,
    input  logic [swmd_pkg::CELL_BITS-1:0]  operand_a,
    input  logic [swmd_pkg::CELL_BITS-1:0]  operand_b,
    input  logic [swmd_pkg::CELL_BITS-1:0]  operand_c,
    output logic                            empty,
    input  logic                            pop,
    output logic [swmd_pkg::CELL_BITS-1:0]  result_low,
    output logic [swmd_pkg::CELL_BITS-1:0]  result_high,
    output logic                            status
);
    import swmd_pkg::*;

`include "stack_word_multiply_divide_unit_top_macros.svh"

    logic   q_wr;
    logic   q_full;
    logic   q_rd;
    logic   q_empty;
    item_t  q_wdata;
    item_t  q_rdata;

    swmd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .operand_c (operand_c),
        .q_wr      (q_wr),
        .q_wdata   (q_wdata),
        .q_full    (q_full)
    );

    swmd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (q_wdata),
        .full  (q_full),
        .rd    (q_rd),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    swmd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_rdata     (q_rdata),
        .q_rd        (q_rd),
        .empty       (empty),
        .pop         (pop),
        .result_low  (result_low),
        .result_high (result_high),
        .status      (status)
    );

    // divide by zero gives zero cells
    `SWMD_ASSERT_NOW(a_zero_div, !empty && status, result_low == '0 && result_high == '0)
    // the back end never reads an empty queue
    `SWMD_ASSERT_NOW(a_no_underrun, q_rd, !q_empty)
    // the front end never writes a full queue
    `SWMD_ASSERT_NOW(a_no_overrun, q_wr, !q_full)

endmodule

// File: verif/stack_word_multiply_divide_unit_top_test.sv
`timescale 1ns / 100ps

import swmd_pkg::*;

class muldiv_scoreboard;
    res_t pending[$];
    int   fails;

    function automatic logic [31:0] mag(logic [31:0] x);
        return x[31] ? -x : x;
    endfunction

    function automatic logic [63:0] signed_divide(logic [63:0] d, logic [31:0] v);
        logic        dneg;
        logic [63:0] dm;
        logic [31:0] q;
        logic [31:0] r;
        dneg = d[63];
        dm = dneg ? -d : d;
        q = 32'(dm / {32'b0, mag(v)});
        r = 32'(dm % {32'b0, mag(v)});
        if (dneg != v[31])
            q = -q;
        if (dneg)
            r = -r;
        return {q, r};
    endfunction

    function automatic res_t forth_word(logic [3:0] op, logic [31:0] a, logic [31:0] b,
                                        logic [31:0] c);
        res_t        res;
        logic [63:0] p;
        logic [63:0] qr;
        logic [31:0] q;
        logic [31:0] r;
        logic        sp;
        res = '0;
        case (op)
            CMD_STAR:
                res.lo = a * b;
            CMD_STARSLASH, CMD_STARSLASHMOD:
                if (c == 0)
                    res.st = 1'b1;
                else
                begin
                    sp = a[31] != b[31];
                    p = {32'b0, mag(a)} * {32'b0, mag(b)};
                    q = 32'(p / {32'b0, mag(c)});
                    r = 32'(p % {32'b0, mag(c)});
                    if (sp)
                        r = -r;
                    if (sp != c[31])
                        q = -q;
                    if (op == CMD_STARSLASH)
                        res.lo = q;
                    else
                    begin
                        res.lo = r;
                        res.hi = q;
                    end
                end
            CMD_SLASH, CMD_SLASHMOD, CMD_MOD:
                if (b == 0)
                    res.st = 1'b1;
                else
                begin
                    qr = signed_divide({{32{a[31]}}, a}, b);
                    if (op == CMD_SLASH)
                        res.lo = qr[63:32];
                    else
                        res.lo = qr[31:0];
                    if (op == CMD_SLASHMOD)
                        res.hi = qr[63:32];
                end
            CMD_FMSLASHMOD, CMD_SMSLASHREM:
                if (c == 0)
                    res.st = 1'b1;
                else
                begin
                    qr = signed_divide({b, a}, c);
                    q = qr[63:32];
                    r = qr[31:0];
                    if (op == CMD_FMSLASHMOD && r != 0 && r[31] != c[31])
                    begin
                        q = q - 1;
                        r = r + c;
                    end
                    res.lo = r;
                    res.hi = q;
                end
            CMD_MSTAR:
            begin
                p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                {res.hi, res.lo} = p;
            end
            CMD_UMSTAR:
                {res.hi, res.lo} = {32'b0, a} * {32'b0, b};
            CMD_UMSLASHMOD:
                if (c == 0)
                    res.st = 1'b1;
                else
                begin
                    res.hi = 32'({b, a} / {32'b0, c});
                    res.lo = 32'({b, a} % {32'b0, c});
                end
            default:
                res = '0;
        endcase
        return res;
    endfunction

    function void note_item(logic [3:0] op, logic [31:0] a, logic [31:0] b, logic [31:0] c);
        pending.push_back(forth_word(op, a, b, c));
    endfunction

    function void check_result(logic [31:0] lo, logic [31:0] hi, logic st);
        res_t want;
        if (pending.size() == 0)
        begin
            $error("result with nothing outstanding");
            fails++;
            return;
        end
        want = pending.pop_front();
        if (lo !== want.lo)
        begin
            $error("result_low expected %h actual %h", want.lo, lo);
            fails++;
        end
        if (hi !== want.hi)
        begin
            $error("result_high expected %h actual %h", want.hi, hi);
            fails++;
        end
        if (st !== want.st)
        begin
            $error("status expected %0d actual %0d", want.st, st);
            fails++;
        end
    endfunction
endclass

module stack_word_multiply_divide_unit_top_test;

    localparam int NUM_RANDOM = 400;
    localparam int STALL_LIMIT = 3000;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [3:0]  cmd;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [31:0] operand_c;
    logic        empty;
    logic        pop;
    logic [31:0] result_low;
    logic [31:0] result_high;
    logic        status;

    muldiv_scoreboard words = new();
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;

    stack_word_multiply_divide_unit_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .cmd(cmd),
        .operand_a(operand_a),
        .operand_b(operand_b),
        .operand_c(operand_c),
        .empty(empty),
        .pop(pop),
        .result_low(result_low),
        .result_high(result_high),
        .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [31:0] rand_cell();
        case ($urandom_range(7))
            0: return 32'h0;
            1: return 32'h1;
            2: return 32'hffff_ffff;
            3: return 32'h8000_0000;
            4: return 32'h7fff_ffff;
            5: return 32'($signed($urandom_range(40)) - 20);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(logic [3:0] op, logic [31:0] a, logic [31:0] b, logic [31:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        cmd <= op;
        operand_a <= a;
        operand_b <= b;
        operand_c <= c;
        do
            @(posedge clk);
        while (full);
        words.note_item(op, a, b, c);
    endtask

    initial
    begin
        forever
        begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
            @(posedge clk);
            if (rst_n && pop && !empty)
                words.check_result(result_low, result_high, status);
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("stack_word_multiply_divide_unit_top: mismatch");
            $finish;
        end
    end

    initial
    begin
        logic [3:0] op;
        rst_n = 1'b0;
        push = 1'b0;
        cmd = 4'b0;
        operand_a = '0;
        operand_b = '0;
        operand_c = '0;
        quiet_cycles = 0;
        send_idle_pct = 8;
        recv_idle_pct = 51;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(CMD_STAR, 32'hffff_ffff, 32'hffff_ffff, 32'h0);
        send_item(CMD_STARSLASH, 32'h7fff_ffff, 32'h7fff_ffff, 32'h3);
        send_item(CMD_STARSLASH, 32'h5, 32'h7, 32'h0);
        send_item(CMD_STARSLASHMOD, 32'hffff_fff9, 32'h3, 32'h2);
        send_item(CMD_STARSLASHMOD, 32'h8000_0000, 32'h8000_0000, 32'h1);
        send_item(CMD_SLASH, 32'h8000_0000, 32'hffff_ffff, 32'hdead_beef);
        send_item(CMD_SLASH, 32'h7, 32'h0, 32'h1);
        send_item(CMD_SLASHMOD, 32'hffff_fff9, 32'h2, 32'h0);
        send_item(CMD_MOD, 32'h7, 32'hffff_fffe, 32'h0);
        send_item(CMD_MOD, 32'h7, 32'h0, 32'h0);
        send_item(CMD_FMSLASHMOD, 32'hffff_fff9, 32'hffff_ffff, 32'h2);
        send_item(CMD_FMSLASHMOD, 32'h7, 32'h0, 32'hffff_fffe);
        send_item(CMD_FMSLASHMOD, 32'h0, 32'h8000_0000, 32'hffff_ffff);
        send_item(CMD_FMSLASHMOD, 32'h1, 32'h1, 32'h0);
        send_item(CMD_SMSLASHREM, 32'hffff_fff9, 32'hffff_ffff, 32'h2);
        send_item(CMD_SMSLASHREM, 32'hffff_ffff, 32'h7fff_ffff, 32'h0);
        send_item(CMD_MSTAR, 32'h8000_0000, 32'h8000_0000, 32'h0);
        send_item(CMD_MSTAR, 32'hffff_ffff, 32'h7fff_ffff, 32'h0);
        send_item(CMD_UMSTAR, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_item(CMD_UMSLASHMOD, 32'hffff_ffff, 32'hffff_fffe, 32'hffff_ffff);
        send_item(CMD_UMSLASHMOD, 32'h0, 32'h5, 32'h3);
        send_item(CMD_UMSLASHMOD, 32'h1, 32'h1, 32'h0);
        send_item(4'(CMD_UMSLASHMOD) + 4'd1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_item(4'hf, 32'h1234_5678, 32'h9abc_def0, 32'h0);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i == NUM_RANDOM / 3)
            begin
                send_idle_pct = 51;
                recv_idle_pct = 8;
            end
            else if (i == 2 * NUM_RANDOM / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(19) == 0)
                op = 4'($urandom_range(15));
            else
                op = 4'($urandom_range(CMD_UMSLASHMOD));
            send_item(op, rand_cell(), rand_cell(), rand_cell());
        end
        push <= 1'b0;

        while (words.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (words.fails == 0)
            $display("stack_word_multiply_divide_unit_top: match");
        else
            $display("stack_word_multiply_divide_unit_top: mismatch");
        $finish;
    end

endmodule
